// ----- hw/rtl/dlm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlm_pkg: shared types for the decimal long multiplier
// Controller states, datapath commands and the status group that the
// datapath returns to the controller.
// ----------------------------------------------------------------------------
package dlm_pkg;

  localparam int unsigned MAX_DIGITS_DEF = 32;
  localparam int unsigned ASCII_ZERO     = 48;
  localparam int unsigned RADIX          = 10;
  localparam int unsigned STREAM_W       = 8;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_LO_RD,
    S_HI_RD0,
    S_HI_RD,
    S_ACC,
    S_HI_WR,
    S_SCAN_RD,
    S_EMIT
  } dlm_state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_START,
    CMD_LO_RD,
    CMD_HI_RD0,
    CMD_HI_RD,
    CMD_ACC,
    CMD_HI_WR,
    CMD_SCAN_RD,
    CMD_SKIP,
    CMD_EMIT
  } dlm_cmd_e;

  typedef struct packed {
    logic end_beat;  // incoming beat closes the second operand
    logic n_zero;    // an operand is empty
    logic ai_zero;   // inner digit index at its last position
    logic bi_zero;   // outer digit index at its last position
    logic rd_nz;     // read product digit is nonzero
    logic at_end;    // scan index on the last product position
    logic skip;      // still stripping leading zeros
    logic out_free;  // output register can take a beat
  } dlm_status_t;

endpackage

// ----- hw/rtl/dlm_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlm_ctrl: sequencer of the decimal long multiplier
// Steps the datapath through operand loading, the multiply-accumulate
// loops and the leading-zero scan and digit output.
// ----------------------------------------------------------------------------
module dlm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  input  dlm_pkg::dlm_status_t status_i,
  output logic                 s_ready_o,
  output dlm_pkg::dlm_cmd_e    cmd_o
);
  import dlm_pkg::*;

  dlm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o     = CMD_NONE;
    s_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o = CMD_LOAD;
          if (status_i.end_beat) begin
            state_d = S_START;
          end
        end
      end
      S_START: begin
        cmd_o   = CMD_START;
        state_d = status_i.n_zero ? S_SCAN_RD : S_LO_RD;
      end
      S_LO_RD: begin
        cmd_o   = CMD_LO_RD;
        state_d = S_HI_RD0;
      end
      S_HI_RD0: begin
        cmd_o   = CMD_HI_RD0;
        state_d = S_ACC;
      end
      S_HI_RD: begin
        cmd_o   = CMD_HI_RD;
        state_d = S_ACC;
      end
      S_ACC: begin
        cmd_o   = CMD_ACC;
        state_d = status_i.ai_zero ? S_HI_WR : S_HI_RD;
      end
      S_HI_WR: begin
        cmd_o   = CMD_HI_WR;
        state_d = status_i.bi_zero ? S_SCAN_RD : S_LO_RD;
      end
      S_SCAN_RD: begin
        cmd_o   = CMD_SCAN_RD;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (status_i.skip && !status_i.rd_nz && !status_i.at_end) begin
          cmd_o   = CMD_SKIP;
          state_d = S_SCAN_RD;
        end else if (status_i.out_free) begin
          cmd_o   = CMD_EMIT;
          state_d = status_i.at_end ? S_IDLE : S_SCAN_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/dlm_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlm_datapath: operand stores, product digit memory and output register
// Holds both operands, runs one digit product per command pair with a
// running column value, and formats product digits for the output stream.
// ----------------------------------------------------------------------------
module dlm_datapath #(
  parameter int unsigned MAX_DIGITS = dlm_pkg::MAX_DIGITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dlm_pkg::dlm_cmd_e             cmd_i,
  input  logic [dlm_pkg::STREAM_W-1:0]  s_tdata_i,
  input  logic                          s_tuser_i,
  input  logic                          s_tlast_i,
  input  logic                          m_tready_i,
  output dlm_pkg::dlm_status_t          status_o,
  output logic                          m_tvalid_o,
  output logic [dlm_pkg::STREAM_W-1:0]  m_tdata_o,
  output logic                          m_tuser_o,
  output logic                          m_tlast_o
);
  import dlm_pkg::*;

  localparam int unsigned IDX_W       = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int unsigned CNT_W       = $clog2(MAX_DIGITS + 1);
  localparam int unsigned TOT_W       = CNT_W + 1;
  localparam int unsigned P_DEPTH     = 2 * MAX_DIGITS;
  localparam int unsigned PA_W        = $clog2(P_DEPTH);
  localparam int unsigned DIV10_MUL   = 205;
  localparam int unsigned DIV10_SHIFT = 11;

  logic [3:0]       first_mem  [MAX_DIGITS];
  logic [3:0]       second_mem [MAX_DIGITS];
  logic [6:0]       prod_mem   [P_DEPTH];
  logic [P_DEPTH-1:0] pvld_q;

  logic [CNT_W-1:0] first_cnt_q, second_cnt_q;
  logic             ovf_q;
  logic [IDX_W-1:0] ai_q, bi_q;
  logic [PA_W-1:0]  k_q;
  logic [TOT_W-1:0] total_q;
  logic             skip_q;
  logic [6:0]       rd_q, mul_q, cur_q;

  logic [5:0]       out_char_q;
  logic             out_last_q, out_ovf_q, out_valid_q;

  // input digit decode, non-digits become zero
  logic [5:0]       in_char;
  logic [3:0]       in_digit;
  logic             first_full, second_full;
  logic             at_end, out_free;

  assign in_char     = s_tdata_i[5:0];
  assign in_digit    = ((in_char >= 6'(ASCII_ZERO)) && (in_char <= 6'(ASCII_ZERO + 9))) ?
                       4'(in_char - 6'(ASCII_ZERO)) : 4'd0;
  assign first_full  = (first_cnt_q == CNT_W'(MAX_DIGITS));
  assign second_full = (second_cnt_q == CNT_W'(MAX_DIGITS));

  // product memory addressing
  logic [PA_W-1:0] hi_addr, lo_addr, rd_addr, wr_addr;
  logic [6:0]      wr_data;
  logic            wr_en, rd_en;

  // column sum and its split into digit and carry
  logic [7:0]  col_sum;
  logic [15:0] col_recip;
  logic [4:0]  col_carry;
  logic [3:0]  col_digit;
  logic [6:0]  chr_sum;

  assign hi_addr   = PA_W'(ai_q) + PA_W'(bi_q);
  assign lo_addr   = hi_addr + PA_W'(1);
  assign col_sum   = {1'b0, mul_q} + {1'b0, cur_q};
  assign col_recip = 16'(col_sum) * 16'(DIV10_MUL);
  assign col_carry = 5'(col_recip >> DIV10_SHIFT);
  assign col_digit = 4'(col_sum - 8'(col_carry) * 8'(RADIX));
  assign chr_sum   = rd_q + 7'(ASCII_ZERO);

  always_comb begin
    rd_addr = k_q;
    rd_en   = 1'b0;
    wr_addr = lo_addr;
    wr_data = {3'b000, col_digit};
    wr_en   = 1'b0;
    case (cmd_i)
      CMD_LO_RD: begin
        rd_addr = lo_addr;
        rd_en   = 1'b1;
      end
      CMD_HI_RD0, CMD_HI_RD: begin
        rd_addr = hi_addr;
        rd_en   = 1'b1;
      end
      CMD_SCAN_RD: begin
        rd_en   = 1'b1;
      end
      CMD_ACC: begin
        wr_en   = 1'b1;
      end
      CMD_HI_WR: begin
        wr_addr = hi_addr;
        wr_data = cur_q;
        wr_en   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign at_end   = ((TOT_W'(k_q) + TOT_W'(1)) == total_q);
  assign out_free = !out_valid_q || m_tready_i;

  // operand stores
  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_LOAD) begin
      if (!s_tuser_i && !first_full) begin
        first_mem[IDX_W'(first_cnt_q)] <= in_digit;
      end
      if (s_tuser_i && !second_full) begin
        second_mem[IDX_W'(second_cnt_q)] <= in_digit;
      end
    end
  end

  // product memory with registered read, unwritten columns read as zero
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      prod_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= pvld_q[rd_addr] ? prod_mem[rd_addr] : 7'd0;
    end
    if (cmd_i == CMD_HI_RD0 || cmd_i == CMD_HI_RD) begin
      mul_q <= 7'(first_mem[ai_q] * second_mem[bi_q]);
    end
    if (cmd_i == CMD_HI_RD0) begin
      cur_q <= rd_q;
    end else if (cmd_i == CMD_ACC) begin
      cur_q <= rd_q + 7'(col_carry);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvld_q       <= '0;
      first_cnt_q  <= '0;
      second_cnt_q <= '0;
      ovf_q        <= 1'b0;
      ai_q         <= '0;
      bi_q         <= '0;
      k_q          <= '0;
      total_q      <= '0;
      skip_q       <= 1'b0;
    end else begin
      if (wr_en) begin
        pvld_q[wr_addr] <= 1'b1;
      end
      case (cmd_i)
        CMD_LOAD: begin
          if (!s_tuser_i) begin
            if (first_full) ovf_q <= 1'b1;
            else first_cnt_q <= first_cnt_q + CNT_W'(1);
          end else begin
            if (second_full) ovf_q <= 1'b1;
            else second_cnt_q <= second_cnt_q + CNT_W'(1);
          end
        end
        CMD_START: begin
          pvld_q  <= '0;
          ai_q    <= IDX_W'(first_cnt_q - CNT_W'(1));
          bi_q    <= IDX_W'(second_cnt_q - CNT_W'(1));
          total_q <= TOT_W'(first_cnt_q) + TOT_W'(second_cnt_q);
          k_q     <= '0;
          skip_q  <= 1'b1;
        end
        CMD_ACC: begin
          if (ai_q != '0) ai_q <= ai_q - IDX_W'(1);
        end
        CMD_HI_WR: begin
          if (bi_q != '0) begin
            bi_q <= bi_q - IDX_W'(1);
            ai_q <= IDX_W'(first_cnt_q - CNT_W'(1));
          end
        end
        CMD_SKIP: begin
          k_q <= k_q + PA_W'(1);
        end
        CMD_EMIT: begin
          k_q    <= k_q + PA_W'(1);
          skip_q <= 1'b0;
          if (at_end) begin
            first_cnt_q  <= '0;
            second_cnt_q <= '0;
            ovf_q        <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i == CMD_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_EMIT) begin
      out_char_q <= chr_sum[5:0];
      out_last_q <= at_end;
      out_ovf_q  <= ovf_q;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {2'b00, out_char_q};
  assign m_tlast_o  = out_last_q;
  assign m_tuser_o  = out_ovf_q;

  assign status_o.end_beat = s_tuser_i && s_tlast_i;
  assign status_o.n_zero   = (first_cnt_q == '0) || (second_cnt_q == '0);
  assign status_o.ai_zero  = (ai_q == '0);
  assign status_o.bi_zero  = (bi_q == '0);
  assign status_o.rd_nz    = (rd_q != 7'd0);
  assign status_o.at_end   = at_end;
  assign status_o.skip     = skip_q;
  assign status_o.out_free = out_free;

endmodule

// ----- hw/rtl/decimal_long_multiplier_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_long_multiplier_core: streaming schoolbook decimal multiplier
// Collects two ASCII digit strings and streams out their product digits.
// ----------------------------------------------------------------------------
// Digits of the first operand (tuser low) and then the second (tuser high)
// are taken one beat per cycle, most significant first; each operand keeps
// up to MAX_DIGITS digits and later ones are dropped and flagged on tuser of
// every product beat. The beat of the second operand with tlast set starts
// the product: the multiply runs a read step and an accumulate step per
// digit product on the single port of the product digit memory, whose
// read data is registered. The product then leaves most significant digit
// first with leading zeros stripped (a zero product is one '0' beat), with
// a read step and an emit or skip step per product position scanned, and
// tlast on the final digit. No input is taken from the closing beat until
// the final digit sits in the output register.
module decimal_long_multiplier_core #(
  parameter int unsigned MAX_DIGITS = dlm_pkg::MAX_DIGITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [dlm_pkg::STREAM_W-1:0] s_axis_tdata,   // [5:0] digit_char
  input  logic                         s_axis_tuser,   // [0] action
  input  logic                         s_axis_tlast,   // last_digit
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [dlm_pkg::STREAM_W-1:0] m_axis_tdata,   // [5:0] result_char
  output logic                         m_axis_tuser,   // [0] overflow
  output logic                         m_axis_tlast    // last
);
  import dlm_pkg::*;

  dlm_cmd_e    cmd;
  dlm_status_t status;

  dlm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .status_i  (status),
    .s_ready_o (s_axis_tready),
    .cmd_o     (cmd)
  );

  dlm_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .s_tlast_i  (s_axis_tlast),
    .m_tready_i (m_axis_tready),
    .status_o   (status),
    .m_tvalid_o (m_axis_tvalid),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser),
    .m_tlast_o  (m_axis_tlast)
  );

  // closing beat of the second operand stops intake for the product run
  a_close_stops_intake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser && s_axis_tlast) |=> !s_axis_tready)
    else $error("input taken right after closing beat");

  // no input while a product is only partly delivered
  a_no_intake_mid_product: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
    else $error("input ready while product digits remain");

  // every product beat is an ascii decimal digit
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:4] == 4'b0011) && (m_axis_tdata[3:0] <= 4'd9))
    else $error("product beat is not a decimal digit");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for decimal_long_multiplier_core
// Streams ASCII digit pairs into the multiplier and works out each product
// with a long-multiplication model of its own. Every product beat is checked
// against that model. The run has three handshake phases: output-side stalls
// heaviest first, then input-side gaps heaviest, then no idling at all.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned MAX_DIGITS   = dlm_pkg::MAX_DIGITS_DEF;
  localparam int unsigned PROD_DIGITS  = 2 * MAX_DIGITS;
  localparam int unsigned PHASE_BEATS  = 80;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam logic        ACT_FIRST    = 1'b0;
  localparam logic        ACT_SECOND   = 1'b1;

  typedef struct packed {
    logic       action;
    logic [5:0] ch;
    logic       last;
  } digit_beat_t;

  typedef struct packed {
    logic [5:0] ch;
    logic       last;
    logic       ovf;
  } prod_beat_t;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [dlm_pkg::STREAM_W-1:0] s_axis_tdata  = '0;  // [5:0] digit_char
  logic                         s_axis_tuser  = 1'b0; // [0] action
  logic                         s_axis_tlast  = 1'b0; // last_digit
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [dlm_pkg::STREAM_W-1:0] m_axis_tdata;         // [5:0] result_char
  logic                         m_axis_tuser;         // [0] overflow
  logic                         m_axis_tlast;         // last

  digit_beat_t digit_q[$];
  prod_beat_t  product_q[$];

  logic [3:0]  op_a [MAX_DIGITS];
  logic [3:0]  op_b [MAX_DIGITS];
  logic [6:0]  col  [PROD_DIGITS];
  int unsigned cnt_a, cnt_b;
  logic        ovf_seen;

  int unsigned send_idle_pct, recv_idle_pct;
  int unsigned beats_queued, beats_in, beats_out, products, ovf_products, errors;

  decimal_long_multiplier_core #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [3:0] char_value(input logic [5:0] c);
    if (c >= dlm_pkg::ASCII_ZERO && c <= dlm_pkg::ASCII_ZERO + 9) begin
      return 4'(c - dlm_pkg::ASCII_ZERO);
    end
    return 4'd0;
  endfunction

  // operand digits accumulate until the closing beat of the second operand
  task automatic predict_product(input digit_beat_t beat);
    logic [3:0]  dv;
    int unsigned total, start, sum, hi;
    prod_beat_t  pb;
    dv = char_value(beat.ch);
    if (beat.action == ACT_FIRST) begin
      if (cnt_a < MAX_DIGITS) begin
        op_a[cnt_a] = dv;
        cnt_a++;
      end else begin
        ovf_seen = 1'b1;
      end
      return;
    end
    if (cnt_b < MAX_DIGITS) begin
      op_b[cnt_b] = dv;
      cnt_b++;
    end else begin
      ovf_seen = 1'b1;
    end
    if (!beat.last) return;

    for (int i = 0; i < PROD_DIGITS; i++) col[i] = '0;
    for (int b = cnt_b; b > 0; b--) begin
      for (int a = cnt_a; a > 0; a--) begin
        hi         = (a - 1) + (b - 1);
        sum        = op_b[b-1] * op_a[a-1] + col[hi+1];
        col[hi+1]  = 7'(sum % dlm_pkg::RADIX);
        col[hi]    = 7'(col[hi] + sum / dlm_pkg::RADIX);
      end
    end

    total = cnt_a + cnt_b;
    if (total > PROD_DIGITS) total = PROD_DIGITS;
    start = 0;
    while (start < total && col[start] == '0) start++;
    if (start >= total) begin
      pb = '{ch: 6'(dlm_pkg::ASCII_ZERO), last: 1'b1, ovf: ovf_seen};
      product_q.push_back(pb);
    end else begin
      for (int unsigned k = start; k < total; k++) begin
        pb.ch   = 6'(col[k] + dlm_pkg::ASCII_ZERO);
        pb.last = (k + 1 == total);
        pb.ovf  = ovf_seen;
        product_q.push_back(pb);
      end
    end
    products++;
    if (ovf_seen) ovf_products++;
    cnt_a    = 0;
    cnt_b    = 0;
    ovf_seen = 1'b0;
  endtask

  task automatic push_beat(input logic act, input logic [5:0] c, input logic lst);
    digit_beat_t beat;
    beat = '{action: act, ch: c, last: lst};
    digit_q.push_back(beat);
    beats_queued++;
  endtask

  function automatic logic [5:0] random_char();
    if ($urandom_range(0, 99) < 10) return 6'($urandom_range(0, 63));
    return 6'($urandom_range(dlm_pkg::ASCII_ZERO, dlm_pkg::ASCII_ZERO + 9));
  endfunction

  // mostly short operands so the multiply stays quick, a few near or past the limit
  function automatic int unsigned pick_len(input int unsigned lo);
    if ($urandom_range(0, 99) < 6) return $urandom_range(MAX_DIGITS - 2, MAX_DIGITS + 2);
    return $urandom_range(lo, 6);
  endfunction

  task automatic queue_operand_pair();
    int unsigned len_a, len_b, n;
    if ($urandom_range(0, 99) < 85) begin
      len_a = pick_len(0);
      len_b = pick_len(1);
      for (int unsigned i = 0; i < len_a; i++) begin
        push_beat(ACT_FIRST, random_char(), 1'($urandom_range(0, 1)));
      end
      for (int unsigned i = 0; i < len_b; i++) begin
        push_beat(ACT_SECOND, random_char(), i + 1 == len_b);
      end
    end else begin
      // loose beats in any order, may or may not close a product
      n = $urandom_range(1, 8);
      repeat (n) begin
        push_beat(1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)),
                  $urandom_range(0, 3) == 0);
      end
    end
  endtask

  // input side
  always @(posedge clk_i or negedge rst_ni) begin : drv
    digit_beat_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
      s_axis_tlast  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_product('{action: s_axis_tuser, ch: s_axis_tdata[5:0], last: s_axis_tlast});
        beats_in++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (digit_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = digit_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {{(dlm_pkg::STREAM_W - 6){1'b0}}, nxt.ch};
          s_axis_tuser  <= nxt.action;
          s_axis_tlast  <= nxt.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // output side
  always @(posedge clk_i or negedge rst_ni) begin : mon
    prod_beat_t                   want;
    logic [dlm_pkg::STREAM_W-1:0] want_data;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        beats_out++;
        if (product_q.size() == 0) begin
          $display("%0t: unexpected product beat data=%h last=%b ovf=%b", $time,
                   m_axis_tdata, m_axis_tlast, m_axis_tuser);
          errors++;
        end else begin
          want      = product_q.pop_front();
          want_data = {{(dlm_pkg::STREAM_W - 6){1'b0}}, want.ch};
          if (m_axis_tdata !== want_data) begin
            $display("%0t: result_char expected %h actual %h", $time, want_data,
                     m_axis_tdata);
            errors++;
          end
          if (m_axis_tlast !== want.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, m_axis_tlast);
            errors++;
          end
          if (m_axis_tuser !== want.ovf) begin
            $display("%0t: overflow expected %b actual %b", $time, want.ovf, m_axis_tuser);
            errors++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : seq
    int unsigned target;
    cnt_a         = 0;
    cnt_b         = 0;
    ovf_seen      = 1'b0;
    send_idle_pct = 23;
    recv_idle_pct = 68;
    beats_queued  = 0;
    beats_in      = 0;
    beats_out     = 0;
    products      = 0;
    ovf_products  = 0;
    errors        = 0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero times zero, last flag on the first operand
    push_beat(ACT_FIRST,  6'("0"), 1'b1);
    push_beat(ACT_SECOND, 6'("0"), 1'b1);
    push_beat(ACT_FIRST,  6'("9"), 1'b0);
    push_beat(ACT_SECOND, 6'("9"), 1'b1);
    // empty first operand
    push_beat(ACT_SECOND, 6'("5"), 1'b1);
    // non-digit characters count as zero
    push_beat(ACT_FIRST,  6'h3f,   1'b0);
    push_beat(ACT_FIRST,  6'("7"), 1'b0);
    push_beat(ACT_SECOND, 6'h00,   1'b0);
    push_beat(ACT_SECOND, 6'("3"), 1'b1);
    // first operand digit after a second operand digit
    push_beat(ACT_SECOND, 6'("2"), 1'b0);
    push_beat(ACT_FIRST,  6'("4"), 1'b0);
    push_beat(ACT_SECOND, 6'("3"), 1'b1);
    // zero product with leading zeros to strip
    push_beat(ACT_FIRST,  6'("1"), 1'b0);
    push_beat(ACT_FIRST,  6'("0"), 1'b0);
    push_beat(ACT_FIRST,  6'("0"), 1'b0);
    push_beat(ACT_SECOND, 6'("0"), 1'b0);
    push_beat(ACT_SECOND, 6'("0"), 1'b1);
    push_beat(ACT_FIRST,  6'("9"), 1'b0);
    push_beat(ACT_FIRST,  6'("9"), 1'b0);
    push_beat(ACT_SECOND, 6'("9"), 1'b0);
    push_beat(ACT_SECOND, 6'("9"), 1'b1);
    // widest product, one digit dropped from each operand
    for (int i = 0; i <= MAX_DIGITS; i++) push_beat(ACT_FIRST, 6'("9"), 1'b0);
    for (int i = 0; i <= MAX_DIGITS; i++) push_beat(ACT_SECOND, 6'("9"), i == MAX_DIGITS);

    for (int ph = 0; ph < 3; ph++) begin
      @(negedge clk_i);
      send_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 68 : 0;
      recv_idle_pct = (ph == 0) ? 68 : (ph == 1) ? 23 : 0;
      target = beats_queued + PHASE_BEATS;
      while (beats_queued < target) queue_operand_pair();
      // close whatever operands are still open
      push_beat(ACT_SECOND, random_char(), 1'b1);
      while (digit_q.size() > 0 || s_axis_tvalid || product_q.size() > 0) begin
        @(negedge clk_i);
      end
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("run covered %0d digit beats in and %0d product beats out", beats_in,
             beats_out);
    $display("%0d products, %0d of them with dropped digits", products, ovf_products);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
